@@ hw/rtl/olt_pkg.sv @@
// ----------------------------------------------------------------------------
// olt_pkg
// shared constants, word types and cell control for the ordered value list
// ----------------------------------------------------------------------------
package olt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 4;
    localparam int WIDE_W   = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam int DATA_W   = 32;

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    localparam logic [2:0] FUNC_INSERT  = 3'd0;
    localparam logic [2:0] FUNC_REMOVE  = 3'd1;
    localparam logic [2:0] FUNC_REPLACE = 3'd2;
    localparam logic [2:0] FUNC_SEARCH  = 3'd3;
    localparam logic [2:0] FUNC_READ    = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [DATA_W-1:0] key_value;
        logic signed [DATA_W-1:0] new_value;
        logic [POS_W-1:0]         position;
    } t_in_word;

    typedef struct packed {
        logic [1:0]               status;
        logic [4:0]               match_count;
        logic signed [DATA_W-1:0] entry_value;
        logic [4:0]               list_length;
    } t_out_word;

    typedef struct packed {
        logic              shift_right;
        logic              shift_left;
        logic              load;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } t_cell_ctrl;

endpackage

@@ hw/rtl/olt_cell.sv @@
// ----------------------------------------------------------------------------
// olt_cell
// one list entry; shifts toward the back on insert, toward the front on scan
// ----------------------------------------------------------------------------
module olt_cell (
    input  logic                       i_clk,
    input  logic [olt_pkg::IDX_W-1:0]  i_index,
    input  logic [olt_pkg::DATA_W-1:0] i_left,
    input  logic [olt_pkg::DATA_W-1:0] i_right,
    input  olt_pkg::t_cell_ctrl        i_ctrl,
    output logic [olt_pkg::DATA_W-1:0] o_value
);

    logic [olt_pkg::DATA_W-1:0] r_value;
    logic [olt_pkg::DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.shift_right) begin
            n_value = i_left;
        end else if (i_ctrl.shift_left) begin
            if (i_ctrl.load && (i_ctrl.idx == i_index)) begin
                n_value = i_ctrl.data;
            end else begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

@@ hw/rtl/olt_ctrl.sv @@
// ----------------------------------------------------------------------------
// olt_ctrl
// sequencer: handshake, length, scan through the cell chain, result register
// ----------------------------------------------------------------------------
module olt_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  olt_pkg::t_in_word          i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output olt_pkg::t_out_word         o_out_word,
    input  logic [olt_pkg::DATA_W-1:0] i_front,
    output olt_pkg::t_cell_ctrl        o_cell_ctrl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    logic [olt_pkg::LEN_W-1:0]    r_length, n_length;
    logic                         r_out_valid, n_out_valid;
    olt_pkg::t_out_word           r_out, n_out;
    logic [2:0]                   r_func, n_func;
    logic [olt_pkg::DATA_W-1:0]   r_key, n_key;
    logic [olt_pkg::DATA_W-1:0]   r_nv, n_nv;
    logic [olt_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [olt_pkg::LEN_W-1:0]    r_step, n_step;
    logic [olt_pkg::LEN_W-1:0]    r_rem, n_rem;
    logic [olt_pkg::LEN_W-1:0]    r_count, n_count;
    logic [olt_pkg::DATA_W-1:0]   r_value, n_value;

    logic                         accept;
    logic                         match;
    logic                         keep;
    logic                         pos_ok;
    logic [olt_pkg::LEN_W-1:0]    tail;

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_state     = r_state;
        n_length    = r_length;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_func      = r_func;
        n_key       = r_key;
        n_nv        = r_nv;
        n_pos       = r_pos;
        n_step      = r_step;
        n_rem       = r_rem;
        n_count     = r_count;
        n_value     = r_value;
        o_cell_ctrl = '0;
        match       = (i_front == r_key);
        keep        = 1'b1;
        tail        = r_length - olt_pkg::LEN_W'(1);
        pos_ok      = olt_pkg::WIDE_W'(i_in_word.position) < olt_pkg::WIDE_W'(r_length);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func  = i_in_word.func;
                    n_key   = i_in_word.key_value;
                    n_nv    = i_in_word.new_value;
                    n_pos   = i_in_word.position;
                    n_step  = '0;
                    n_rem   = r_length;
                    n_count = '0;
                    n_value = '0;
                    n_out   = '{status: olt_pkg::ST_DONE, match_count: 5'd0,
                                entry_value: '0, list_length: 5'(r_length)};
                    case (i_in_word.func)
                        olt_pkg::FUNC_INSERT: begin
                            n_out_valid = 1'b1;
                            if (r_length < olt_pkg::CAP_LEN) begin
                                o_cell_ctrl.shift_right = 1'b1;
                                o_cell_ctrl.data        = i_in_word.key_value;
                                n_length                = r_length + olt_pkg::LEN_W'(1);
                                n_out.list_length       = 5'(n_length);
                            end else begin
                                n_out.status = olt_pkg::ST_FULL;
                            end
                        end
                        olt_pkg::FUNC_REMOVE, olt_pkg::FUNC_REPLACE,
                        olt_pkg::FUNC_SEARCH: begin
                            if (r_length == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = olt_pkg::ST_NOMATCH;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        olt_pkg::FUNC_READ: begin
                            if (pos_ok) begin
                                n_state = S_SCAN;
                            end else begin
                                n_out_valid  = 1'b1;
                                n_out.status = olt_pkg::ST_RANGE;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // pop the front, append it or its replacement at the tail unless it is removed
                case (r_func)
                    olt_pkg::FUNC_REMOVE:  keep = !match;
                    default:               keep = 1'b1;
                endcase
                o_cell_ctrl.shift_left = 1'b1;
                o_cell_ctrl.load       = keep;
                o_cell_ctrl.idx        = tail[olt_pkg::IDX_W-1:0];
                o_cell_ctrl.data       = (r_func == olt_pkg::FUNC_REPLACE && match) ?
                                         r_nv : i_front;
                if (!keep) begin
                    n_length = tail;
                end
                if (match) begin
                    n_count = r_count + olt_pkg::LEN_W'(1);
                end
                if (olt_pkg::WIDE_W'(r_step) == olt_pkg::WIDE_W'(r_pos)) begin
                    n_value = i_front;
                end
                n_step = r_step + olt_pkg::LEN_W'(1);
                n_rem  = r_rem - olt_pkg::LEN_W'(1);
                if (r_rem == olt_pkg::LEN_W'(1)) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '{status: olt_pkg::ST_DONE, match_count: 5'd0,
                                    entry_value: '0, list_length: 5'(n_length)};
                    case (r_func)
                        olt_pkg::FUNC_READ: begin
                            n_out.entry_value = n_value;
                        end
                        olt_pkg::FUNC_SEARCH: begin
                            if (n_count != '0) begin
                                n_out.match_count = 5'd1;
                            end else begin
                                n_out.status = olt_pkg::ST_NOMATCH;
                            end
                        end
                        default: begin
                            n_out.match_count = 5'(n_count);
                            if (n_count == '0) begin
                                n_out.status = olt_pkg::ST_NOMATCH;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_length    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_length    <= n_length;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_func  <= n_func;
        r_key   <= n_key;
        r_nv    <= n_nv;
        r_pos   <= n_pos;
        r_step  <= n_step;
        r_rem   <= n_rem;
        r_count <= n_count;
        r_value <= n_value;
    end

endmodule

@@ hw/rtl/ordered_value_list_table.sv @@
// ----------------------------------------------------------------------------
// ordered_value_list_table
// bounded ordered list of signed values held in a chain of cells
// ----------------------------------------------------------------------------
// insert, unused codes, and scans of an empty list or out of range reads:
//   result word valid the cycle after the word is taken, next word then too unless the output stalls
// remove, replace, search and read: result word registered when a scan of
//   all L entries ends, one cell shift per cycle around the chain, one word
//   in flight; next word taken with the result valid, if output not stalled
// reset: list empty, no result pending; cell contents are left unset
module ordered_value_list_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  olt_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output olt_pkg::t_out_word o_out_word
);

    olt_pkg::t_cell_ctrl        cell_ctrl;
    logic [olt_pkg::DATA_W-1:0] cell_val [olt_pkg::CAPACITY];

    olt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_front     (cell_val[0]),
        .o_cell_ctrl (cell_ctrl)
    );

    for (genvar g = 0; g < olt_pkg::CAPACITY; g++) begin : g_cell
        logic [olt_pkg::DATA_W-1:0] left;
        logic [olt_pkg::DATA_W-1:0] right;

        if (g == 0) begin : g_first
            assign left = cell_ctrl.data;
        end else begin : g_mid_l
            assign left = cell_val[g-1];
        end

        if (g == olt_pkg::CAPACITY - 1) begin : g_last
            assign right = cell_val[g];
        end else begin : g_mid_r
            assign right = cell_val[g+1];
        end

        olt_cell u_cell (
            .i_clk   (i_clk),
            .i_index (olt_pkg::IDX_W'(g)),
            .i_left  (left),
            .i_right (right),
            .i_ctrl  (cell_ctrl),
            .o_value (cell_val[g])
        );
    end

endmodule

@@ test/ordered_value_list_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_value_list_table_tb
// self-checking bench for the bounded ordered value list
// ----------------------------------------------------------------------------
// drives list operations over the valid/stall input channel and predicts
// each result word from a shadow copy of the list; covers empty and full
// lists, duplicate keys, reads past the end and unused function codes, a
// long output hold-off that fills the block and stalls its input, then
// random traffic under several idle and stall mixes
module ordered_value_list_table_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_GAP   = 2 * olt_pkg::CAPACITY + 8;
    localparam int PHASE_ITEMS = 225;
    localparam int POOL_SIZE   = 8;

    localparam logic [2:0] FUNC_NOP_FIRST = 3'd5;
    localparam logic [2:0] FUNC_NOP_LAST  = 3'd7;

    localparam logic signed [olt_pkg::DATA_W-1:0] VAL_MIN =
        {1'b1, {(olt_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [olt_pkg::DATA_W-1:0] VAL_MAX =
        {1'b0, {(olt_pkg::DATA_W-1){1'b1}}};

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    olt_pkg::t_in_word  i_in_word;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    olt_pkg::t_out_word o_out_word;

    logic signed [olt_pkg::DATA_W-1:0] shadow_vals [olt_pkg::CAPACITY];
    int                                shadow_len = 0;
    logic signed [olt_pkg::DATA_W-1:0] value_pool [POOL_SIZE];
    olt_pkg::t_out_word                pending_results[$];

    int fail_count    = 0;
    int cycle_count   = 0;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int hold_left     = 0;
    int hold_reqs     = 0;
    int hold_seen     = 0;

    ordered_value_list_table u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // applies one operation to the shadow list and returns its result word
    function automatic olt_pkg::t_out_word predict_list_op(input olt_pkg::t_in_word w);
        olt_pkg::t_out_word r;
        int                 i;
        int                 n;
        int                 wr;
        r  = '0;
        n  = 0;
        wr = 0;
        case (w.func)
            olt_pkg::FUNC_INSERT: begin
                if (shadow_len >= olt_pkg::CAPACITY) begin
                    r.status = olt_pkg::ST_FULL;
                end else begin
                    for (i = shadow_len; i > 0; i--) shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[0] = w.key_value;
                    shadow_len++;
                end
            end
            olt_pkg::FUNC_REMOVE: begin
                for (i = 0; i < shadow_len; i++) begin
                    if (shadow_vals[i] == w.key_value) begin
                        n++;
                    end else begin
                        shadow_vals[wr] = shadow_vals[i];
                        wr++;
                    end
                end
                shadow_len = wr;
            end
            olt_pkg::FUNC_REPLACE: begin
                for (i = 0; i < shadow_len; i++) begin
                    if (shadow_vals[i] == w.key_value) begin
                        shadow_vals[i] = w.new_value;
                        n++;
                    end
                end
            end
            olt_pkg::FUNC_SEARCH: begin
                for (i = 0; i < shadow_len; i++) begin
                    if (shadow_vals[i] == w.key_value) n = 1;
                end
            end
            olt_pkg::FUNC_READ: begin
                if (int'(w.position) < shadow_len) begin
                    r.entry_value = shadow_vals[w.position];
                end else begin
                    r.status = olt_pkg::ST_RANGE;
                end
            end
            default: ;
        endcase
        if (w.func inside {olt_pkg::FUNC_REMOVE, olt_pkg::FUNC_REPLACE,
                           olt_pkg::FUNC_SEARCH}) begin
            r.match_count = 5'(n);
            if (n == 0) r.status = olt_pkg::ST_NOMATCH;
        end
        r.list_length = 5'(shadow_len);
        return r;
    endfunction

    function automatic void compare_field(input string name,
                                          input logic signed [olt_pkg::DATA_W:0] want,
                                          input logic signed [olt_pkg::DATA_W:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // result checking first, then prediction for a word taken at this edge
    always @(posedge i_clk) begin : result_monitor
        olt_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing pending: %h", o_out_word);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", want.status, o_out_word.status);
                compare_field("match_count", want.match_count, o_out_word.match_count);
                compare_field("entry_value", want.entry_value, o_out_word.entry_value);
                compare_field("list_length", want.list_length, o_out_word.list_length);
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            pending_results.push_back(predict_list_op(i_in_word));
        end
    end

    // output side: long hold-off on request, random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    function automatic olt_pkg::t_in_word make_op(
        input logic [2:0]                        f,
        input logic signed [olt_pkg::DATA_W-1:0] key,
        input logic signed [olt_pkg::DATA_W-1:0] nv,
        input logic [olt_pkg::POS_W-1:0]         pos);
        olt_pkg::t_in_word w;
        w.func      = f;
        w.key_value = key;
        w.new_value = nv;
        w.position  = pos;
        return w;
    endfunction

    function automatic logic signed [olt_pkg::DATA_W-1:0] pick_value();
        if ($urandom_range(99) < 75) return value_pool[$urandom_range(POOL_SIZE-1)];
        return $urandom;
    endfunction

    function automatic olt_pkg::t_in_word random_list_op();
        int         roll;
        logic [2:0] f;
        roll = $urandom_range(99);
        if (roll < 30)      f = olt_pkg::FUNC_INSERT;
        else if (roll < 48) f = olt_pkg::FUNC_REMOVE;
        else if (roll < 60) f = olt_pkg::FUNC_REPLACE;
        else if (roll < 70) f = olt_pkg::FUNC_SEARCH;
        else if (roll < 93) f = olt_pkg::FUNC_READ;
        else                f = 3'($urandom_range(FUNC_NOP_LAST, FUNC_NOP_FIRST));
        return make_op(f, pick_value(), pick_value(),
                       olt_pkg::POS_W'($urandom_range(15)));
    endfunction

    task automatic send_list_op(input olt_pkg::t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic test_directed_ops();
        logic [2:0] f;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        send_list_op(make_op(olt_pkg::FUNC_READ, 0, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_SEARCH, 5, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_REMOVE, 5, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_REPLACE, 5, 6, 0));
        for (f = FUNC_NOP_FIRST; f != olt_pkg::FUNC_INSERT; f++) begin
            send_list_op(make_op(f, $urandom, $urandom,
                                 olt_pkg::POS_W'($urandom_range(15))));
        end
        send_list_op(make_op(olt_pkg::FUNC_INSERT, VAL_MIN, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_INSERT, VAL_MAX, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_INSERT, 0, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_INSERT, -1, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_INSERT, VAL_MAX, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_READ, 0, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_READ, 0, 0, 4));
        send_list_op(make_op(olt_pkg::FUNC_READ, 0, 0, 5));
        send_list_op(make_op(olt_pkg::FUNC_READ, 0, 0, 15));
        send_list_op(make_op(olt_pkg::FUNC_SEARCH, VAL_MAX, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_SEARCH, 1, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_REPLACE, VAL_MAX, VAL_MIN, 0));
        send_list_op(make_op(olt_pkg::FUNC_REMOVE, VAL_MIN, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_READ, 0, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_REPLACE, -1, $urandom, 0));
        send_list_op(make_op(olt_pkg::FUNC_SEARCH, 0, 0, 0));
        wait_results_drained();
    endtask

    // inserts run into a full list while the output is held off, then scans of the full list
    task automatic test_full_list_backpressure();
        int                                i;
        logic signed [olt_pkg::DATA_W-1:0] dup;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        dup           = $urandom;
        hold_reqs++;
        for (i = 0; i <= olt_pkg::CAPACITY; i++) begin
            send_list_op(make_op(olt_pkg::FUNC_INSERT, (i % 2 == 0) ? dup : $urandom, 0, 0));
        end
        send_list_op(make_op(olt_pkg::FUNC_READ, 0, 0, 15));
        send_list_op(make_op(olt_pkg::FUNC_READ, 0, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_SEARCH, dup, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_REPLACE, dup, ~dup, 0));
        send_list_op(make_op(olt_pkg::FUNC_REMOVE, ~dup, 0, 0));
        send_list_op(make_op(olt_pkg::FUNC_READ, 0, 0, 7));
        wait_results_drained();
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int i;
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = 0;
        value_pool[3] = -1;
        for (i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
        for (i = 0; i < PHASE_ITEMS; i++) send_list_op(random_list_op());
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0);
        run_random_phase(88, 0);
        run_random_phase(0, 88);
        run_random_phase(32, 32);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_full_list_backpressure();
        test_random_traffic();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/olt_pkg.sv
hw/rtl/olt_cell.sv
hw/rtl/olt_ctrl.sv
hw/rtl/ordered_value_list_table.sv
test/ordered_value_list_table_tb.sv
